// ===== design/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
package rhc_pkg;

  localparam int CHAN_BITS = 8;
  localparam int HUE_BITS = 9;
  localparam int SAT_BITS = 8;
  localparam int NUM_BITS = 11;
  localparam int HUE_REM_BITS = 17;
  localparam int SAT_REM_BITS = 16;
  localparam int DIV_STAGES = HUE_BITS;

  localparam logic [1:0] SECTOR_RED = 2'd0;
  localparam logic [1:0] SECTOR_BLUE = 2'd1;
  localparam logic [1:0] SECTOR_GREEN = 2'd2;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    logic [CHAN_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [HUE_REM_BITS-1:0] hue_rem;
    logic [SAT_REM_BITS-1:0] sat_rem;
    logic [CHAN_BITS-1:0] delta;
    logic [CHAN_BITS-1:0] mx;
    logic [HUE_BITS-1:0] hue_q;
    logic [SAT_BITS-1:0] sat_q;
    logic grey;
  } div_word_t;

endpackage

// ===== design/rgb_to_hsv_convert.sv =====
// Top level of the pipelined 8-bit RGB to HSV pixel converter.
//
// One pixel transaction enters on the pixel channel (pixel_valid, pixel_ready,
// pixel) and one HSV transaction leaves on the hsv channel (hsv_valid,
// hsv_ready, hsv) for every pixel, in the same order.
// The pipeline has twelve register stages: three for the channel max and min,
// the hue numerator and the constant products, then nine divider stages that
// each resolve one quotient bit of hue and, all but the first, one of saturation.
// Throughput is one pixel per cycle while the receiver does not stall; all stages advance together.
// When the receiver stalls a valid result, the whole pipeline holds and
// pixel_ready drops in the same cycle, so nothing is lost or repeated.
// Grey pixels bypass the quotient and give zero hue and saturation.
// A synchronous reset empties every stage; data registers are not cleared.
module rgb_to_hsv_convert
  import rhc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_ready,
  output hsv_t   hsv
);

  logic advance;

  logic                 s1_valid;
  logic [CHAN_BITS-1:0] s1_mx;
  logic [CHAN_BITS-1:0] s1_mn;
  logic [CHAN_BITS-1:0] s1_red;
  logic [CHAN_BITS-1:0] s1_green;
  logic [CHAN_BITS-1:0] s1_blue;
  logic [1:0]           s1_sector;

  logic                 s2_valid;
  logic [CHAN_BITS-1:0] s2_mx;
  logic [CHAN_BITS-1:0] s2_delta;
  logic [NUM_BITS-1:0]  s2_num;

  logic      s3_valid;
  div_word_t s3;

  logic [CHAN_BITS-1:0] mx_next;
  logic [CHAN_BITS-1:0] mn_next;
  logic [1:0]           sector_next;
  logic [CHAN_BITS-1:0] delta_next;
  logic [NUM_BITS-1:0]  num_next;
  logic [NUM_BITS-1:0]  delta_wide;
  div_word_t            s3_next;

  logic      done_valid;
  div_word_t done;

  assign advance = !hsv_valid || hsv_ready;
  assign pixel_ready = advance;

  always_comb begin
    mx_next = (pixel.red > pixel.green) ? pixel.red : pixel.green;
    mx_next = (mx_next > pixel.blue) ? mx_next : pixel.blue;
    mn_next = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    mn_next = (mn_next < pixel.blue) ? mn_next : pixel.blue;
    if (pixel.red == mn_next) begin
      sector_next = SECTOR_RED;
    end else if (pixel.blue == mn_next) begin
      sector_next = SECTOR_BLUE;
    end else begin
      sector_next = SECTOR_GREEN;
    end
  end

  always_comb begin
    delta_next = s1_mx - s1_mn;
    delta_wide = {{(NUM_BITS-CHAN_BITS){1'b0}}, delta_next};
    case (s1_sector)
      SECTOR_RED: begin
        num_next = (delta_wide << 1) + delta_wide
                   + {{(NUM_BITS-CHAN_BITS){1'b0}}, s1_blue}
                   - {{(NUM_BITS-CHAN_BITS){1'b0}}, s1_green};
      end
      SECTOR_BLUE: begin
        num_next = delta_wide
                   + {{(NUM_BITS-CHAN_BITS){1'b0}}, s1_green}
                   - {{(NUM_BITS-CHAN_BITS){1'b0}}, s1_red};
      end
      default: begin
        num_next = (delta_wide << 2) + delta_wide
                   + {{(NUM_BITS-CHAN_BITS){1'b0}}, s1_red}
                   - {{(NUM_BITS-CHAN_BITS){1'b0}}, s1_blue};
      end
    endcase
  end

  always_comb begin
    logic [HUE_REM_BITS-1:0] num_ext;
    logic [SAT_REM_BITS-1:0] delta_ext;
    num_ext = {{(HUE_REM_BITS-NUM_BITS){1'b0}}, s2_num};
    delta_ext = {{(SAT_REM_BITS-CHAN_BITS){1'b0}}, s2_delta};
    s3_next.hue_rem = (num_ext << 6) - (num_ext << 2);
    s3_next.sat_rem = (delta_ext << 8) - delta_ext;
    s3_next.delta = s2_delta;
    s3_next.mx = s2_mx;
    s3_next.hue_q = '0;
    s3_next.sat_q = '0;
    s3_next.grey = (s2_delta == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pixel_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mx <= mx_next;
      s1_mn <= mn_next;
      s1_red <= pixel.red;
      s1_green <= pixel.green;
      s1_blue <= pixel.blue;
      s1_sector <= sector_next;
      s2_mx <= s1_mx;
      s2_delta <= delta_next;
      s2_num <= num_next;
      s3 <= s3_next;
    end
  end

  rhc_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .load_valid (s3_valid),
    .load       (s3),
    .done_valid (done_valid),
    .done       (done)
  );

  assign hsv_valid = done_valid;
  assign hsv.hue = done.grey ? '0 : done.hue_q;
  assign hsv.saturation = done.grey ? '0 : done.sat_q;
  assign hsv.brightness = done.mx;

endmodule

// ===== design/rhc_divider.sv =====
// Pipelined restoring divider: each stage gives a hue bit, all but the first a saturation bit.
module rhc_divider
  import rhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      load_valid,
  input  div_word_t load,
  output logic      done_valid,
  output div_word_t done
);

  logic      stage_valid [DIV_STAGES];
  div_word_t stage       [DIV_STAGES];
  div_word_t stage_next  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int BIT = DIV_STAGES - 1 - j;
    div_word_t prev;
    logic      prev_valid;
    logic [HUE_REM_BITS-1:0] hue_sub;

    if (j == 0) begin : g_first
      assign prev = load;
      assign prev_valid = load_valid;
    end else begin : g_rest
      assign prev = stage[j-1];
      assign prev_valid = stage_valid[j-1];
    end

    assign hue_sub = {{(HUE_REM_BITS-CHAN_BITS){1'b0}}, prev.delta} << BIT;

    if (BIT < SAT_BITS) begin : g_sat
      logic [SAT_REM_BITS-1:0] sat_sub;
      assign sat_sub = {{(SAT_REM_BITS-CHAN_BITS){1'b0}}, prev.mx} << BIT;
      always_comb begin
        stage_next[j] = prev;
        if (prev.hue_rem >= hue_sub) begin
          stage_next[j].hue_rem = prev.hue_rem - hue_sub;
          stage_next[j].hue_q[BIT] = 1'b1;
        end
        if (prev.sat_rem >= sat_sub) begin
          stage_next[j].sat_rem = prev.sat_rem - sat_sub;
          stage_next[j].sat_q[BIT] = 1'b1;
        end
      end
    end else begin : g_hue_only
      always_comb begin
        stage_next[j] = prev;
        if (prev.hue_rem >= hue_sub) begin
          stage_next[j].hue_rem = prev.hue_rem - hue_sub;
          stage_next[j].hue_q[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[j] <= 1'b0;
      end else if (advance) begin
        stage_valid[j] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage[j] <= stage_next[j];
      end
    end
  end

  assign done_valid = stage_valid[DIV_STAGES-1];
  assign done = stage[DIV_STAGES-1];

endmodule

// ===== design/rhc_checker.sv =====
// Port-level assertions for the RGB to HSV converter and the bind that attaches them.
module rhc_checker
  import rhc_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   pixel_valid,
  input logic   pixel_ready,
  input logic   hsv_valid,
  input logic   hsv_ready,
  input hsv_t   hsv
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready |=> hsv_valid && $stable(hsv))
    else $error("Stalled hsv transaction changed or dropped.");

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    pixel_ready == (!hsv_valid || hsv_ready))
    else $error("Pixel ready does not track the output stall.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !hsv_valid)
    else $error("Result valid right after reset.");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue < 9'd360)
    else $error("Hue out of range.");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.saturation == '0 |-> hsv.hue == '0)
    else $error("Zero saturation with nonzero hue.");

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (.*);

// ===== bench/rgb_to_hsv_convert_test.sv =====
// Self-checking testbench that drives RGB pixels through the HSV converter and checks every result.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_test;
  import rhc_pkg::*;

  localparam int PIXEL_COUNT = 400;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int LONG_HOLD_CYCLES = 90;
  localparam int DRAIN_CYCLES = 20;

  class hsv_scoreboard;
    hsv_t expected_q[$];
    int unsigned pixels_in;
    int unsigned greys_in;
    int unsigned results_checked;
    int unsigned mismatches;

    function hsv_t convert_pixel(pixel_t p);
      int unsigned mx;
      int unsigned mn;
      int unsigned delta;
      int unsigned num;
      logic [1:0] sector;
      hsv_t r;
      mx = 32'(p.red);
      if (32'(p.green) > mx) mx = 32'(p.green);
      if (32'(p.blue) > mx) mx = 32'(p.blue);
      mn = 32'(p.red);
      if (32'(p.green) < mn) mn = 32'(p.green);
      if (32'(p.blue) < mn) mn = 32'(p.blue);
      delta = mx - mn;
      r.hue = '0;
      r.saturation = '0;
      r.brightness = mx[CHAN_BITS-1:0];
      if (delta != 0) begin
        if (32'(p.red) == mn) sector = SECTOR_RED;
        else if (32'(p.blue) == mn) sector = SECTOR_BLUE;
        else sector = SECTOR_GREEN;
        case (sector)
          SECTOR_RED: num = 3 * delta + int'(p.blue) - int'(p.green);
          SECTOR_BLUE: num = delta + int'(p.green) - int'(p.red);
          default: num = 5 * delta + int'(p.red) - int'(p.blue);
        endcase
        r.hue = HUE_BITS'((60 * num) / delta);
        r.saturation = SAT_BITS'((255 * delta) / mx);
      end
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      pixels_in++;
      if (p.red == p.green && p.green == p.blue) greys_in++;
      expected_q.push_back(convert_pixel(p));
    endfunction

    function void check_hsv(hsv_t got);
      hsv_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected HSV transaction hue %0d sat %0d val %0d",
                   $realtime, got.hue, got.saturation, got.brightness);
        return;
      end
      want = expected_q.pop_front();
      if (got.hue !== want.hue || got.saturation !== want.saturation ||
          got.brightness !== want.brightness) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
                   $realtime, results_checked, want.hue, want.saturation, want.brightness,
                   got.hue, got.saturation, got.brightness);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic pixel_valid;
  logic pixel_ready;
  pixel_t pixel;
  logic hsv_valid;
  logic hsv_ready;
  hsv_t hsv;

  hsv_scoreboard board;
  int unsigned idle_cycles;

  rgb_to_hsv_convert uut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .hsv_valid(hsv_valid),
    .hsv_ready(hsv_ready),
    .hsv(hsv)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (hsv_valid && hsv_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("rgb_to_hsv_convert verification failed");
        $finish;
      end
    end
  end

  // Starts and ends at a falling edge; valid stays high across back-to-back pixels.
  task automatic send_pixel(input pixel_t p, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (!pixel_ready);
    board.note_pixel(pixel);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int unsigned kind;
    int unsigned odd_one;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] pair;
    logic [7:0] odd;
    logic [5:0] bits;
    p.red = CHAN_BITS'($urandom);
    p.green = CHAN_BITS'($urandom);
    p.blue = CHAN_BITS'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        p.green = p.red;
        p.blue = p.red;
      end
      1, 2: begin
        lo = CHAN_BITS'($urandom_range(0, 254));
        hi = CHAN_BITS'($urandom_range(32'(lo) + 1, 255));
        pair = (kind == 1) ? lo : hi;
        odd = (kind == 1) ? hi : lo;
        odd_one = $urandom_range(0, 2);
        p.red = pair;
        p.green = pair;
        p.blue = pair;
        case (odd_one)
          0: p.red = odd;
          1: p.green = odd;
          default: p.blue = odd;
        endcase
      end
      3: begin
        bits = 6'($urandom);
        p.red = {{7{bits[0]}}, bits[1]};
        p.green = {{7{bits[2]}}, bits[3]};
        p.blue = {{7{bits[4]}}, bits[5]};
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    hsv_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
      if (taken == 40) stall = LONG_HOLD_CYCLES;
      if (stall > 0) begin
        hsv_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      hsv_ready <= 1'b1;
      do @(posedge clk); while (!hsv_valid);
      board.check_hsv(hsv);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    logic [23:0] directed_codes [25];
    int i;
    bit calm;
    directed_codes = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
      24'h010000, 24'h000100, 24'h000001, 24'hFFFEFE, 24'hFEFFFE,
      24'hFEFEFF, 24'h0A0AC8, 24'hC80A0A, 24'h0AC80A, 24'hFF0100,
      24'h01FF00, 24'h00FF01, 24'hAA5500, 24'hC86432, 24'h010203
    };
    board = new();
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Corners, primaries, minimum ties and the wrap just below 360 degrees.
    for (i = 0; i < 25; i++) send_pixel(pixel_t'(directed_codes[i]), 1'b0);
    pixel_valid <= 1'b0;
    wait_for_drain();

    for (i = 0; i < PIXEL_COUNT; i++) begin
      if (i == PIXEL_COUNT / 2) begin
        pixel_valid <= 1'b0;
        wait_for_drain();
      end
      calm = ((i / 40) % 3 == 2);
      send_pixel(random_pixel(), calm);
    end
    pixel_valid <= 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d pixels, %0d of them grey, under random gaps and result stalls.",
             board.pixels_in, board.greys_in);
    $display("Checked %0d HSV transactions, %0d mismatched.",
             board.results_checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("rgb_to_hsv_convert verification clean");
    end else begin
      $display("rgb_to_hsv_convert verification failed");
    end
    $finish;
  end

endmodule
